/* src/tcce_pkg.sv */
// Shared types, character codes and default geometry for the text console engine.
package tcce_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Width used to widen cell indexes before comparing or trimming them.
    localparam int WIDE_W = 16;

    localparam logic       CMD_PUT  = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    localparam logic [7:0] CH_BS          = 8'h08;
    localparam logic [7:0] CH_TAB         = 8'h09;
    localparam logic [7:0] CH_LF          = 8'h0A;
    localparam logic [7:0] CH_CR          = 8'h0D;
    localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CH_LAST_PRINT  = 8'h7F;
    localparam logic [6:0] CELL_BLANK     = 7'h20;

    typedef struct packed {
        logic        command;
        logic [7:0]  character;
        logic [10:0] cell_address;
    } t_item;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [6:0]  cell_data;
        logic        scrolled;
    } t_result;

    // What a put does besides moving the cursor.
    typedef struct packed {
        logic write;
        logic scroll;
    } t_put_info;

endpackage

/* src/tcce_screen_mem.sv */
// Screen store: one write port and one registered read port.
module tcce_screen_mem #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [6:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [6:0]    o_rdata
);

    logic [6:0] r_mem [DEPTH];
    logic [6:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tcce_cursor.sv */
// Cursor registers and the next-position logic for put items.
module tcce_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int CW      = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char,
    output logic [CW-1:0]       o_cursor,
    output logic [CW-1:0]       o_next,
    output tcce_pkg::t_put_info o_info
);
    import tcce_pkg::*;

    localparam int COLW = $clog2(COLUMNS + 8);
    localparam int RW   = $clog2(ROWS);

    logic [CW-1:0]   r_cursor, n_cursor;
    logic [COLW-1:0] r_col, n_col;
    logic [RW-1:0]   r_row, n_row;

    logic [3:0]      adv;
    logic [COLW-1:0] col_sum;
    logic            printable;
    logic [CW-1:0]   mv_cursor;
    logic [COLW-1:0] mv_col;
    logic [RW-1:0]   mv_row;
    logic            need_scroll;

    assign printable = (i_char >= CH_FIRST_PRINT) && (i_char <= CH_LAST_PRINT);

    always_comb begin
        mv_cursor = r_cursor;
        mv_col    = r_col;
        mv_row    = r_row;
        // Tab always moves between one and eight cells.
        adv       = (i_char == CH_TAB) ? (4'd8 - {1'b0, r_cursor[2:0]}) : 4'd1;
        col_sum   = r_col + COLW'(adv);
        priority if (i_char == CH_BS) begin
            if (r_cursor != '0) begin
                mv_cursor = r_cursor - CW'(1);
                if (r_col == '0) begin
                    mv_col = COLW'(COLUMNS - 1);
                    mv_row = r_row - RW'(1);
                end else begin
                    mv_col = r_col - COLW'(1);
                end
            end
        end else if (i_char == CH_CR) begin
            mv_cursor = r_cursor - CW'(r_col);
            mv_col    = '0;
        end else if (i_char == CH_LF) begin
            mv_cursor = r_cursor + CW'(COLUMNS) - CW'(r_col);
            mv_col    = '0;
            mv_row    = r_row + RW'(1);
        end else if ((i_char == CH_TAB) || printable) begin
            mv_cursor = r_cursor + CW'(adv);
            if (col_sum >= COLW'(COLUMNS)) begin
                mv_col = col_sum - COLW'(COLUMNS);
                mv_row = r_row + RW'(1);
            end else begin
                mv_col = col_sum;
            end
        end else begin
            // Any other byte leaves the cursor where it is.
            mv_cursor = r_cursor;
        end
    end

    assign need_scroll = (mv_row == RW'(ROWS - 1));

    always_comb begin
        n_cursor = mv_cursor;
        n_col    = mv_col;
        n_row    = mv_row;
        if (need_scroll) begin
            n_cursor = mv_cursor - CW'(COLUMNS);
            n_row    = mv_row - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_step) begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    assign o_cursor      = r_cursor;
    assign o_next        = n_cursor;
    assign o_info.write  = printable;
    assign o_info.scroll = need_scroll;

endmodule

/* src/text_console_character_engine_top.sv */
// Top level of the text console engine: sequencer, store sweeps and result register.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------
//  command   | start in, busy out        | i_item   (t_item)
//  result    | o_done strobe, one cycle  | o_result (t_result)
//
// A put item that does not scroll returns its result in the cycle after
// acceptance and busy stays low, so puts may follow every cycle.
// A read item holds busy in the read state while the registered store port
// returns the cell, and its result is registered as that state ends.
// A put that scrolls sweeps the whole store, one cell a cycle through the read
// port and the write port, and holds busy through the sweep and its flush.
// After reset a clearing pass fills the store with spaces while busy is
// high. The receiver cannot stall results.
module text_console_character_engine_top #(
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcce_pkg::DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tcce_pkg::t_item   i_item,
    output logic              o_done,
    output tcce_pkg::t_result o_result
);
    import tcce_pkg::*;

    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SCROLL_LIMIT = COLUMNS * (ROWS - 1);
    localparam int AW           = $clog2(CELLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]    r_state;
    logic [AW-1:0] r_k;          // sweep position: destination of the next copy
    logic          r_clear;      // sweep blanks every cell rather than scrolling
    logic          r_wv;         // sweep write stage holds a cell
    logic [AW-1:0] r_wa;
    logic          r_wblank;
    logic          r_rd_ok;
    logic          r_done;
    t_result       r_res;

    logic          accept;
    logic          put_go;
    logic [AW-1:0] cursor;
    logic [AW-1:0] next_cursor;
    t_put_info     put_info;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [6:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [6:0]    mem_rdata;

    logic [AW:0]   src_addr;
    logic          k_blank;
    logic          addr_ok;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign put_go = accept && (i_item.command == CMD_PUT);

    tcce_cursor #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS),
        .CW     (AW)
    ) u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (put_go),
        .i_char  (i_item.character),
        .o_cursor(cursor),
        .o_next  (next_cursor),
        .o_info  (put_info)
    );

    // The sweep reads the cell one row below its destination; the copy lands
    // in the cycle after the read, always behind the read front, so no source
    // is overwritten before it has been read.
    assign src_addr = {1'b0, r_k} + (AW + 1)'(COLUMNS);
    assign k_blank  = r_clear || ({1'b0, r_k} >= (AW + 1)'(SCROLL_LIMIT));
    assign addr_ok  = WIDE_W'(i_item.cell_address) < WIDE_W'(CELLS);

    always_comb begin
        mem_raddr = AW'(WIDE_W'(i_item.cell_address));
        if (r_state == ST_SWEEP) begin
            mem_raddr = src_addr[AW-1:0];
        end
    end

    // The sweep write stage and a put never meet: puts are taken only when idle.
    always_comb begin
        if (r_wv) begin
            mem_we    = 1'b1;
            mem_waddr = r_wa;
            mem_wdata = r_wblank ? CELL_BLANK : mem_rdata;
        end else begin
            mem_we    = put_go && put_info.write;
            mem_waddr = cursor;
            mem_wdata = i_item.character[6:0];
        end
    end

    tcce_screen_mem #(
        .DEPTH(CELLS),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Control sequence: reset starts a blanking sweep, a scrolling put starts a
    // copying sweep, and each sweep ends in the flush state for the last write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_k     <= '0;
            r_clear <= 1'b1;
            r_wv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_item.command == CMD_READ) begin
                            r_state <= ST_READ;
                        end else if (put_info.scroll) begin
                            r_state <= ST_SWEEP;
                            r_k     <= '0;
                            r_clear <= 1'b0;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                ST_READ: begin
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                ST_SWEEP: begin
                    r_wv <= 1'b1;
                    r_k  <= r_k + AW'(1);
                    if (r_k == AW'(CELLS - 1)) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_wv    <= 1'b0;
                    r_done  <= !r_clear;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Sweep write stage and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SWEEP) begin
            r_wa     <= r_k;
            r_wblank <= k_blank;
        end
        if (accept) begin
            r_rd_ok <= addr_ok;
        end
        if (put_go) begin
            r_res.cursor_position <= 11'(WIDE_W'(next_cursor));
            r_res.cell_data       <= '0;
            r_res.scrolled        <= 1'b0;
        end else if (r_state == ST_READ) begin
            r_res.cursor_position <= 11'(WIDE_W'(cursor));
            r_res.cell_data       <= r_rd_ok ? mem_rdata : 7'd0;
            r_res.scrolled        <= 1'b0;
        end else if (r_state == ST_FLUSH) begin
            r_res.cursor_position <= 11'(WIDE_W'(cursor));
            r_res.cell_data       <= '0;
            r_res.scrolled        <= 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // A read item returns its result once it has passed through the read state.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.command == CMD_READ)) |=> ##1 o_done)
        else $error("read item did not return its result in time");

    // A put that does not scroll returns an unscrolled result at once.
    a_put_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (put_go && !put_info.scroll) |=> (o_done && !o_result.scrolled))
        else $error("non-scrolling put did not return at once");

    // A scrolled result only follows the flush cycle of a copying sweep.
    a_scroll_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.scrolled) |-> ($past(r_state) == ST_FLUSH))
        else $error("scrolled result outside a sweep");

    // Sweep writes occur only while a sweep or its flush is in progress.
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> ((r_state == ST_SWEEP) || (r_state == ST_FLUSH)))
        else $error("sweep write stage active outside a sweep");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the text console character engine, with predictor and checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    // The block is built at its default geometry, and the predictor keeps the same sizes.
    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int SCROLL_LIMIT = COLUMNS * (ROWS - 1);
    localparam int ITEM_TOTAL   = 1400;
    localparam int QUIET_ITEMS  = 200;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    t_item   i_item  = '0;
    logic    o_done;
    t_result o_result;

    text_console_character_engine_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Items waiting to be driven, and results expected back, oldest first.
    t_item   pending_items[$];
    t_result awaited_results[$];

    // The predictor's own copy of the screen and the cursor.
    logic [6:0]  screen_shadow [0:CELLS-1];
    int unsigned cursor_shadow;

    int   mismatch_count = 0;
    int   items_queued   = 0;
    int   idle_left      = 0;
    logic item_accepted  = 1'b0;
    logic idling_on      = 1'b1;
    logic quiet_tail     = 1'b0;

    // Works out the result of one item and updates the shadow screen and cursor.
    // A put may move the cursor into the last row; the screen then scrolls up by one row.
    function automatic t_result console_step(t_item it);
        t_result     res;
        int unsigned col;
        int          idx;
        res = '0;
        if (it.command == CMD_PUT) begin
            col = cursor_shadow % COLUMNS;
            case (it.character)
                CH_BS: begin
                    if (cursor_shadow > 0)
                        cursor_shadow = cursor_shadow - 1;
                end
                CH_TAB: begin
                    cursor_shadow = (cursor_shadow + 8) & ~32'd7;
                end
                CH_CR: begin
                    cursor_shadow = cursor_shadow - col;
                end
                CH_LF: begin
                    cursor_shadow = cursor_shadow + COLUMNS - col;
                end
                default: begin
                    if (it.character >= CH_FIRST_PRINT && it.character <= CH_LAST_PRINT) begin
                        if (cursor_shadow < CELLS)
                            screen_shadow[cursor_shadow] = it.character[6:0];
                        cursor_shadow = cursor_shadow + 1;
                    end
                end
            endcase
            if (cursor_shadow >= SCROLL_LIMIT) begin
                for (idx = 0; idx < SCROLL_LIMIT; idx++)
                    screen_shadow[idx] = screen_shadow[idx + COLUMNS];
                for (idx = SCROLL_LIMIT; idx < CELLS; idx++)
                    screen_shadow[idx] = CELL_BLANK;
                cursor_shadow = cursor_shadow - COLUMNS;
                res.scrolled = 1'b1;
            end
        end else if (it.cell_address < CELLS) begin
            res.cell_data = screen_shadow[it.cell_address];
        end
        res.cursor_position = cursor_shadow[10:0];
        return res;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        mismatch_count = mismatch_count + 1;
    endtask

    // Monitor. Outputs are sampled at the rising edge, so o_done and busy hold the values
    // of the cycle that this edge ends. Results are checked before the item taken at the
    // same edge is predicted; no item can have its result on the edge that accepts it.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing expected: cursor %0d data %h",
                                        o_result.cursor_position, o_result.cell_data));
            end else begin
                want = awaited_results.pop_front();
                if (o_result.cursor_position !== want.cursor_position)
                    flag_mismatch($sformatf("cursor_position %0d, expected %0d",
                                            o_result.cursor_position, want.cursor_position));
                if (o_result.cell_data !== want.cell_data)
                    flag_mismatch($sformatf("cell_data %h, expected %h",
                                            o_result.cell_data, want.cell_data));
                if (o_result.scrolled !== want.scrolled)
                    flag_mismatch($sformatf("scrolled %b, expected %b",
                                            o_result.scrolled, want.scrolled));
            end
        end
        if (i_rst_n && start && !busy)
            awaited_results.push_back(console_step(i_item));
        item_accepted <= i_rst_n && start && !busy;
    end

    // Driver. Inputs change at the falling edge. An item stays on the ports until the
    // monitor has seen it taken; start is written at most once per edge, so a
    // back-to-back item never lowers and raises it in the same step.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else if (!start || item_accepted) begin
            if (idle_left > 0) begin
                start <= 1'b0;
                idle_left = idle_left - 1;
            end else if (pending_items.size() != 0) begin
                i_item <= pending_items.pop_front();
                start  <= 1'b1;
                if (idling_on && !quiet_tail && $urandom_range(0, 3) == 0)
                    idle_left = $urandom_range(1, 13);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Hands one item to the driver, keeping only a short backlog so that reads aimed near
    // the cursor are chosen from a fairly fresh view of the shadow state.
    task automatic queue_item(input logic cmd, input logic [7:0] ch, input logic [10:0] addr);
        t_item it;
        while (pending_items.size() >= 4)
            @(posedge i_clk);
        it.command      = cmd;
        it.character    = ch;
        it.cell_address = addr;
        pending_items.push_back(it);
        items_queued = items_queued + 1;
        quiet_tail   = (items_queued >= ITEM_TOTAL - QUIET_ITEMS);
    endtask

    // Stimulus: a directed opening, then random sequences until the item count is reached.
    initial begin
        int          kind;
        int          seq_len;
        int          k;
        int          target;
        logic [7:0]  ch;
        for (k = 0; k < CELLS; k++)
            screen_shadow[k] = CELL_BLANK;
        cursor_shadow = 0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reads of a freshly cleared screen, the last cell and beyond the end of the store.
        queue_item(CMD_READ, 8'h00, 11'd0);
        queue_item(CMD_READ, 8'hFF, 11'(CELLS - 1));
        queue_item(CMD_READ, 8'h55, 11'(CELLS));
        queue_item(CMD_READ, 8'hAA, 11'h7FF);
        // Backspace with the cursor already at cell zero must leave it there.
        queue_item(CMD_PUT, CH_BS, 11'h7FF);
        // The first and last printable codes, then an ordinary letter.
        queue_item(CMD_PUT, CH_FIRST_PRINT, 11'd0);
        queue_item(CMD_PUT, CH_LAST_PRINT, 11'h555);
        queue_item(CMD_PUT, 8'h41, 11'h2AA);
        queue_item(CMD_READ, 8'h00, 11'd1);
        queue_item(CMD_READ, 8'h00, 11'd2);
        // A tab from an odd column, a tab from a multiple of eight, then moves back.
        queue_item(CMD_PUT, CH_TAB, 11'd0);
        queue_item(CMD_PUT, CH_TAB, 11'd0);
        queue_item(CMD_PUT, CH_BS, 11'd0);
        queue_item(CMD_PUT, CH_CR, 11'd0);
        queue_item(CMD_PUT, CH_LF, 11'd0);
        // Bytes that are neither handled controls nor printable change nothing; then one letter.
        queue_item(CMD_PUT, 8'h00, 11'h7FF);
        queue_item(CMD_PUT, 8'h1F, 11'h7FF);
        queue_item(CMD_PUT, 8'h80, 11'h7FF);
        queue_item(CMD_PUT, 8'hFF, 11'h7FF);
        queue_item(CMD_PUT, 8'h0B, 11'h000);
        queue_item(CMD_PUT, 8'h5A, 11'h000);
        queue_item(CMD_READ, 8'hFF, 11'(COLUMNS));
        queue_item(CMD_READ, 8'hFF, 11'd0);

        while (items_queued < ITEM_TOTAL) begin
            kind      = $urandom_range(0, 9);
            // Some sequences run with no idling at all on the sending side.
            idling_on = ($urandom_range(0, 2) != 0);
            if (kind <= 3) begin
                // A line of text, ended by a newline, a carriage return, both or nothing.
                seq_len = $urandom_range(1, 70);
                for (k = 0; k < seq_len; k++)
                    queue_item(CMD_PUT, 8'($urandom_range(32, 127)),
                               11'($urandom_range(0, 2047)));
                case ($urandom_range(0, 3))
                    0: queue_item(CMD_PUT, CH_LF, 11'($urandom_range(0, 2047)));
                    1: begin
                        queue_item(CMD_PUT, CH_CR, 11'($urandom_range(0, 2047)));
                        queue_item(CMD_PUT, CH_LF, 11'($urandom_range(0, 2047)));
                    end
                    2: queue_item(CMD_PUT, CH_CR, 11'($urandom_range(0, 2047)));
                    default: ;
                endcase
            end else if (kind <= 5) begin
                // Read back what was just written near the cursor, some of the bottom row and cells anywhere.
                seq_len = $urandom_range(2, 10);
                for (k = 0; k < seq_len; k++) begin
                    case ($urandom_range(0, 2))
                        0: target = $urandom_range(SCROLL_LIMIT, CELLS - 1);
                        1: target = $urandom_range(0, CELLS - 1);
                        default: begin
                            target = int'(cursor_shadow) - int'($urandom_range(1, 8));
                            if (target < 0)
                                target = 0;
                        end
                    endcase
                    queue_item(CMD_READ, 8'($urandom_range(0, 255)), 11'(target));
                end
            end else if (kind <= 7) begin
                // Noise: control codes, bytes with the top bit set and reads anywhere,
                // out-of-range addresses included.
                seq_len = $urandom_range(3, 12);
                for (k = 0; k < seq_len; k++) begin
                    case ($urandom_range(0, 5))
                        0: ch = CH_BS;
                        1: ch = CH_TAB;
                        2: ch = 8'($urandom_range(0, 31));
                        3: ch = 8'($urandom_range(128, 255));
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        queue_item(CMD_READ, ch, 11'($urandom_range(0, 2047)));
                    else
                        queue_item(CMD_PUT, ch, 11'($urandom_range(0, 2047)));
                end
            end else if (kind == 8) begin
                // A run of line feeds, which drives the cursor down into repeated scrolls.
                seq_len = $urandom_range(5, 30);
                for (k = 0; k < seq_len; k++)
                    queue_item(CMD_PUT, CH_LF, 11'($urandom_range(0, 2047)));
            end else begin
                // A long unbroken run of text wraps across rows and scrolls on a character.
                seq_len = $urandom_range(80, 160);
                for (k = 0; k < seq_len; k++)
                    queue_item(CMD_PUT, 8'($urandom_range(32, 127)),
                               11'($urandom_range(0, 2047)));
            end
        end

        // Drain: everything driven, taken and answered, then a wait longer than a scroll
        // so that a stray late result would still be caught.
        while (pending_items.size() != 0 || start || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (CELLS + 16) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Guard against a hung block; the bound covers every item scrolling, well over.
    initial begin
        #(80_000_000);
        $display("testbench: done, errors");
        $finish;
    end

endmodule

/* files.f */
src/tcce_pkg.sv
src/tcce_screen_mem.sv
src/tcce_cursor.sv
src/text_console_character_engine_top.sv
bench/testbench.sv
